// File: hw/rtl/rpp_pkg.sv
// Shared types, panel constants and register codes for the rotated pixel plot block.
// No dependencies; every other file in hw/rtl refers to this package by scoped names.
package rpp_pkg;

  // Panel geometry
  localparam int PANEL_WIDTH  = 128;
  localparam int PANEL_HEIGHT = 296;
  localparam int PANEL_MAX    = (PANEL_WIDTH > PANEL_HEIGHT) ? PANEL_WIDTH : PANEL_HEIGHT;
  localparam int STORE_DEPTH  = PANEL_WIDTH * ((PANEL_HEIGHT + 7) / 8);

  // Derived widths
  localparam int COORD_W = $clog2(PANEL_MAX);
  localparam int LIN_W   = $clog2(PANEL_WIDTH * PANEL_HEIGHT);
  localparam int ADDR_W  = $clog2(STORE_DEPTH);

  // Field widths fixed by the interface
  localparam int POS_W      = 16;
  localparam int COLOR_W    = 16;
  localparam int OUT_ADDR_W = 13;
  localparam int BYTE_W     = 8;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;

  // Colour probe bits: top bit of red, green and blue
  localparam int COLOR_R_BIT = 15;
  localparam int COLOR_G_BIT = 10;
  localparam int COLOR_B_BIT = 4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROTATION       = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_RED_MAPS_WHITE = CFG_IDX_W'(1);

  // Rotation codes
  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rotation_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [COLOR_W-1:0]      rgb_color;
  } pixel_in_t;

  typedef struct packed {
    logic                  plotted;
    logic [OUT_ADDR_W-1:0] byte_address;
    logic [BYTE_W-1:0]     byte_value;
  } pixel_out_t;

  // Mapped pixel after the coordinate stage
  typedef struct packed {
    logic               valid;
    logic               inb;
    logic               white;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] py;
  } map_t;

  // Byte request handed to the read-modify-write stage
  typedef struct packed {
    logic              valid;
    logic              inb;
    logic              white;
    logic [ADDR_W-1:0] addr;
    logic [2:0]        bit_sel;
  } req_t;

endpackage

// File: hw/rtl/rpp_addr_gen.sv
// Front end: bounds check, colour class, rotation mapping and byte address generation.
// Two register stages; depends on rpp_pkg.
module rpp_addr_gen (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic                take,
  input  rpp_pkg::pixel_in_t  pix,
  input  rpp_pkg::rotation_t  rotation,
  input  logic                red_maps_white,
  output rpp_pkg::req_t       req
);

  localparam logic [rpp_pkg::COORD_W-1:0] W_M1 = rpp_pkg::COORD_W'(rpp_pkg::PANEL_WIDTH - 1);
  localparam logic [rpp_pkg::COORD_W-1:0] H_M1 = rpp_pkg::COORD_W'(rpp_pkg::PANEL_HEIGHT - 1);

  rpp_pkg::map_t map_q;
  rpp_pkg::map_t map_next;
  logic [rpp_pkg::POS_W-2:0]   lim_x;
  logic [rpp_pkg::POS_W-2:0]   lim_y;
  logic                        x_ok;
  logic                        y_ok;
  logic [2:0]                  probe;
  logic [rpp_pkg::COORD_W-1:0] xs;
  logic [rpp_pkg::COORD_W-1:0] ys;
  logic [rpp_pkg::LIN_W-1:0]   lin;

  // Bounds against the rotated size; negatives fail on the sign bit
  always_comb begin
    lim_x = rotation[0] ? (rpp_pkg::POS_W-1)'(rpp_pkg::PANEL_HEIGHT)
                        : (rpp_pkg::POS_W-1)'(rpp_pkg::PANEL_WIDTH);
    lim_y = rotation[0] ? (rpp_pkg::POS_W-1)'(rpp_pkg::PANEL_WIDTH)
                        : (rpp_pkg::POS_W-1)'(rpp_pkg::PANEL_HEIGHT);
    x_ok  = !pix.pos_x[rpp_pkg::POS_W-1] && (pix.pos_x[rpp_pkg::POS_W-2:0] < lim_x);
    y_ok  = !pix.pos_y[rpp_pkg::POS_W-1] && (pix.pos_y[rpp_pkg::POS_W-2:0] < lim_y);
  end

  // Colour class and coordinate mapping; col is W-1-px
  always_comb begin
    probe = {pix.rgb_color[rpp_pkg::COLOR_R_BIT], pix.rgb_color[rpp_pkg::COLOR_G_BIT],
             pix.rgb_color[rpp_pkg::COLOR_B_BIT]};
    xs    = pix.pos_x[rpp_pkg::COORD_W-1:0];
    ys    = pix.pos_y[rpp_pkg::COORD_W-1:0];
    map_next.valid = take;
    map_next.inb   = x_ok && y_ok;
    if (probe == 3'b000) begin
      map_next.white = 1'b0;
    end else if (probe == 3'b111) begin
      map_next.white = 1'b1;
    end else begin
      map_next.white = red_maps_white;
    end
    case (rotation)
      rpp_pkg::ROT_0: begin
        map_next.col = W_M1 - xs;
        map_next.py  = H_M1 - ys;
      end
      rpp_pkg::ROT_90: begin
        map_next.col = W_M1 - ys;
        map_next.py  = xs;
      end
      rpp_pkg::ROT_180: begin
        map_next.col = xs;
        map_next.py  = ys;
      end
      rpp_pkg::ROT_270: begin
        map_next.col = ys;
        map_next.py  = H_M1 - xs;
      end
      default: begin
        map_next.col = xs;
        map_next.py  = ys;
      end
    endcase
  end

  // Linear bit index: col * H + py
  assign lin = rpp_pkg::LIN_W'(map_q.col) * rpp_pkg::LIN_W'(rpp_pkg::PANEL_HEIGHT)
             + rpp_pkg::LIN_W'(map_q.py);

  // Stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      map_q.valid <= 1'b0;
      req.valid   <= 1'b0;
    end else if (advance) begin
      map_q.valid <= map_next.valid;
      req.valid   <= map_q.valid;
    end
    if (advance) begin
      map_q.inb   <= map_next.inb;
      map_q.white <= map_next.white;
      map_q.col   <= map_next.col;
      map_q.py    <= map_next.py;
      req.inb     <= map_q.inb;
      req.white   <= map_q.white;
      req.addr    <= rpp_pkg::ADDR_W'(lin >> 3);
      req.bit_sel <= map_q.py[2:0];
    end
  end

endmodule

// File: hw/rtl/rpp_frame_mem.sv
// Framebuffer byte store: one write port, one read port with registered read data.
// Depends on rpp_pkg for depth and widths.
module rpp_frame_mem (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [rpp_pkg::ADDR_W-1:0]  wr_addr,
  input  logic [rpp_pkg::BYTE_W-1:0]  wr_data,
  input  logic                        rd_en,
  input  logic [rpp_pkg::ADDR_W-1:0]  rd_addr,
  output logic [rpp_pkg::BYTE_W-1:0]  rd_data
);

  logic [rpp_pkg::BYTE_W-1:0] mem [rpp_pkg::STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/rpp_rmw.sv
// Read-modify-write of one framebuffer byte, with forwarding from the last write.
// Also runs the clearing sweep after reset. Depends on rpp_pkg.
module rpp_rmw (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        advance,
  input  rpp_pkg::req_t               req,
  input  logic [rpp_pkg::BYTE_W-1:0]  rd_data,
  output logic                        clear_done,
  output logic                        wr_en,
  output logic [rpp_pkg::ADDR_W-1:0]  wr_addr,
  output logic [rpp_pkg::BYTE_W-1:0]  wr_data,
  output rpp_pkg::pixel_out_t         result
);

  localparam logic [rpp_pkg::ADDR_W-1:0] LAST_ADDR = rpp_pkg::ADDR_W'(rpp_pkg::STORE_DEPTH - 1);

  logic [rpp_pkg::ADDR_W-1:0] clr_addr;
  logic                       fwd_valid;
  logic [rpp_pkg::ADDR_W-1:0] fwd_addr;
  logic [rpp_pkg::BYTE_W-1:0] fwd_data;
  logic [rpp_pkg::BYTE_W-1:0] old_byte;
  logic [rpp_pkg::BYTE_W-1:0] mask;
  logic [rpp_pkg::BYTE_W-1:0] new_byte;
  logic                       px_write;

  // Clearing sweep, one byte a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr   <= '0;
      clear_done <= 1'b0;
    end else if (!clear_done) begin
      clr_addr <= clr_addr + rpp_pkg::ADDR_W'(1);
      if (clr_addr == LAST_ADDR) begin
        clear_done <= 1'b1;
      end
    end
  end

  // Modify: the most recent write to the same byte wins over the read data
  always_comb begin
    old_byte = (fwd_valid && (fwd_addr == req.addr)) ? fwd_data : rd_data;
    mask     = 8'h80 >> req.bit_sel;
    new_byte = req.white ? (old_byte | mask) : (old_byte & ~mask);
    px_write = advance && req.valid && req.inb;
  end

  // Write port shared between sweep and pixel writes
  always_comb begin
    if (!clear_done) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = '0;
    end else begin
      wr_en   = px_write;
      wr_addr = req.addr;
      wr_data = new_byte;
    end
  end

  // Last-write register for forwarding
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (px_write) begin
      fwd_valid <= 1'b1;
    end
    if (px_write) begin
      fwd_addr <= req.addr;
      fwd_data <= new_byte;
    end
  end

  // Result fields; a dropped pixel reports zeros
  always_comb begin
    result.plotted      = req.inb;
    result.byte_address = req.inb ? rpp_pkg::OUT_ADDR_W'(req.addr) : '0;
    result.byte_value   = req.inb ? new_byte : '0;
  end

endmodule

// File: hw/rtl/rotated_pixel_plot_1bpp_top.sv
// Top level of the rotated 1 bpp pixel plotter; ties the address front end, the
// read-modify-write stage and the framebuffer memory together. Depends on rpp_pkg.
//
// Plots one pixel per transaction into a 1-bit-per-pixel framebuffer of
// PANEL_WIDTH * ceil(PANEL_HEIGHT/8) bytes and returns the byte it changed. After
// reset the block clears all STORE_DEPTH bytes (4736 at 128 x 296) one byte a cycle
// and holds in_ready low until that is done; configuration
// writes are taken throughout. Afterwards it takes one pixel every cycle while the
// output side keeps up: a pixel passes the coordinate stage, the address multiply
// stage, the memory read and the output register before its result appears.
// Back-to-back pixels hitting the same byte are handled by forwarding the last
// written byte into the modify step, so no bubble is needed. A stall on out_ready
// freezes the whole pipeline.
module rotated_pixel_plot_1bpp_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  rpp_pkg::pixel_in_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output rpp_pkg::pixel_out_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rpp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rpp_pkg::CFG_DATA_W-1:0]  cfg_data
);

  rpp_pkg::rotation_t         rotation;
  logic                       red_maps_white;
  logic                       advance;
  logic                       take;
  logic                       clear_done;
  rpp_pkg::req_t              req_s2;
  rpp_pkg::req_t              req_s3;
  rpp_pkg::pixel_out_t        result;
  logic [rpp_pkg::BYTE_W-1:0] rd_data;
  logic                       wr_en;
  logic [rpp_pkg::ADDR_W-1:0] wr_addr;
  logic [rpp_pkg::BYTE_W-1:0] wr_data;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rotation       <= rpp_pkg::ROT_0;
      red_maps_white <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        rpp_pkg::REG_ROTATION:       rotation <= rpp_pkg::rotation_t'(cfg_data[1:0]);
        rpp_pkg::REG_RED_MAPS_WHITE: red_maps_white <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Pipeline moves whenever the output register is free or being drained
  assign advance  = !out_valid || out_ready;
  assign in_ready = advance && clear_done;
  assign take     = in_valid && in_ready;

  rpp_addr_gen u_addr_gen (
    .clk            (clk),
    .rst            (rst),
    .advance        (advance),
    .take           (take),
    .pix            (in_data),
    .rotation       (rotation),
    .red_maps_white (red_maps_white),
    .req            (req_s2)
  );

  // Request travels alongside the memory read
  always_ff @(posedge clk) begin
    if (rst) begin
      req_s3.valid <= 1'b0;
    end else if (advance) begin
      req_s3.valid <= req_s2.valid;
    end
    if (advance) begin
      req_s3.inb     <= req_s2.inb;
      req_s3.white   <= req_s2.white;
      req_s3.addr    <= req_s2.addr;
      req_s3.bit_sel <= req_s2.bit_sel;
    end
  end

  rpp_frame_mem u_frame_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (advance && req_s2.valid && req_s2.inb),
    .rd_addr (req_s2.addr),
    .rd_data (rd_data)
  );

  rpp_rmw u_rmw (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .req        (req_s3),
    .rd_data    (rd_data),
    .clear_done (clear_done),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .result     (result)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= req_s3.valid;
    end
    if (advance) begin
      out_data <= result;
    end
  end

  // No pixel is taken while the clearing sweep runs
  a_no_take_while_clearing: assert property (@(posedge clk) disable iff (rst)
    !clear_done |-> !in_ready)
    else $error("input accepted during framebuffer clear");

  // Nothing reaches the modify stage before the clear has finished
  a_rmw_after_clear: assert property (@(posedge clk) disable iff (rst)
    req_s3.valid |-> clear_done)
    else $error("pixel in modify stage before clear finished");

  // A dropped pixel reports zero address and value
  a_drop_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.plotted) |->
      (out_data.byte_address == '0 && out_data.byte_value == '0))
    else $error("dropped pixel with non-zero result fields");

  // A stalled output freezes the memory write port for pixels
  a_no_write_on_stall: assert property (@(posedge clk) disable iff (rst)
    (clear_done && !advance) |-> !wr_en)
    else $error("framebuffer written while pipeline stalled");

endmodule

// File: verif/tb_rotated_pixel_plot_1bpp_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for rotated_pixel_plot_1bpp_top: a directed table, then
// random pixel traffic at several handshake pacings, every result checked against a
// table entry or a behavioural framebuffer predictor. Depends on rpp_pkg and the top-level RTL only.
module tb_rotated_pixel_plot_1bpp_top;

  // Margin allowed when draining after the last expected result
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int ITEMS_PER_PHASE = 185;
  localparam rpp_pkg::pixel_out_t DROPPED = '0;

  typedef enum logic {ROW_PIXEL, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t                      kind;
    rpp_pkg::pixel_in_t             pix;
    bit                             typed;
    rpp_pkg::pixel_out_t            want;
    logic [rpp_pkg::CFG_IDX_W-1:0]  idx;
    logic [rpp_pkg::CFG_DATA_W-1:0] val;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  rpp_pkg::pixel_in_t in_data;
  logic out_valid;
  logic out_ready;
  rpp_pkg::pixel_out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [rpp_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [rpp_pkg::CFG_DATA_W-1:0] cfg_data;

  // Shadow framebuffer and register copies
  logic [7:0] shadow_frame [rpp_pkg::STORE_DEPTH];
  rpp_pkg::rotation_t shadow_rotation = rpp_pkg::ROT_0;
  bit         shadow_red_white = 1'b0;

  rpp_pkg::pixel_out_t expected_writes [$];
  stim_row_t  stim_table [$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_request = 0;
  int err_count = 0;
  int plotted_count = 0;
  int dropped_count = 0;
  int prev_x = 0;
  int prev_y = 0;

  rotated_pixel_plot_1bpp_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 2 ns clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Predict one plot and update the shadow framebuffer
  function automatic rpp_pkg::pixel_out_t plot_pixel(rpp_pkg::pixel_in_t p);
    rpp_pkg::pixel_out_t r;
    int x, y, lim_x, lim_y, px, py, addr;
    logic [2:0] probe;
    bit white;
    logic [7:0] cur;
    r = DROPPED;
    x = $signed(p.pos_x);
    y = $signed(p.pos_y);
    lim_x = shadow_rotation[0] ? rpp_pkg::PANEL_HEIGHT : rpp_pkg::PANEL_WIDTH;
    lim_y = shadow_rotation[0] ? rpp_pkg::PANEL_WIDTH : rpp_pkg::PANEL_HEIGHT;
    if (x < 0 || x >= lim_x || y < 0 || y >= lim_y) return r;
    probe = {p.rgb_color[rpp_pkg::COLOR_R_BIT], p.rgb_color[rpp_pkg::COLOR_G_BIT],
             p.rgb_color[rpp_pkg::COLOR_B_BIT]};
    if (probe == 3'b000) white = 1'b0;
    else if (probe == 3'b111) white = 1'b1;
    else white = shadow_red_white;
    case (shadow_rotation)
      rpp_pkg::ROT_0: begin
        px = x;
        py = rpp_pkg::PANEL_HEIGHT - 1 - y;
      end
      rpp_pkg::ROT_90: begin
        px = y;
        py = x;
      end
      rpp_pkg::ROT_180: begin
        px = rpp_pkg::PANEL_WIDTH - 1 - x;
        py = y;
      end
      default: begin
        px = rpp_pkg::PANEL_WIDTH - 1 - y;
        py = rpp_pkg::PANEL_HEIGHT - 1 - x;
      end
    endcase
    addr = ((rpp_pkg::PANEL_WIDTH - 1 - px) * rpp_pkg::PANEL_HEIGHT + py) >> 3;
    if (addr >= rpp_pkg::STORE_DEPTH) return r;
    cur = shadow_frame[addr];
    cur[7 - (py % 8)] = white;
    shadow_frame[addr] = cur;
    r.plotted = 1'b1;
    r.byte_address = rpp_pkg::OUT_ADDR_W'(addr);
    r.byte_value = cur;
    return r;
  endfunction

  function automatic void add_pixel(int x, int y, int colour, bit typed,
                                    rpp_pkg::pixel_out_t want);
    stim_row_t row;
    row.kind = ROW_PIXEL;
    row.pix.pos_x = rpp_pkg::POS_W'(x);
    row.pix.pos_y = rpp_pkg::POS_W'(y);
    row.pix.rgb_color = rpp_pkg::COLOR_W'(colour);
    row.typed = typed;
    row.want = want;
    row.idx = '0;
    row.val = '0;
    stim_table.push_back(row);
  endfunction

  function automatic void add_reg(logic [rpp_pkg::CFG_IDX_W-1:0] idx,
                                  logic [rpp_pkg::CFG_DATA_W-1:0] val);
    stim_row_t row;
    row.kind = ROW_REG;
    row.pix = '0;
    row.typed = 1'b0;
    row.want = DROPPED;
    row.idx = idx;
    row.val = val;
    stim_table.push_back(row);
  endfunction

  // Mostly in-bounds pixels, some in the previous byte (rotations 0 and 180), some pure noise
  function automatic rpp_pkg::pixel_in_t random_pixel();
    rpp_pkg::pixel_in_t p;
    int lim_x, lim_y, mode, colour_class;
    lim_x = shadow_rotation[0] ? rpp_pkg::PANEL_HEIGHT : rpp_pkg::PANEL_WIDTH;
    lim_y = shadow_rotation[0] ? rpp_pkg::PANEL_WIDTH : rpp_pkg::PANEL_HEIGHT;
    mode = $urandom_range(99);
    if (mode < 15) begin
      p.pos_x = rpp_pkg::POS_W'(prev_x);
      p.pos_y = rpp_pkg::POS_W'((prev_y & ~7) | $urandom_range(7));
    end else if (mode < 82) begin
      p.pos_x = rpp_pkg::POS_W'($urandom_range(lim_x - 1));
      p.pos_y = rpp_pkg::POS_W'($urandom_range(lim_y - 1));
    end else if (mode < 88) begin
      // just past either edge
      p.pos_x = rpp_pkg::POS_W'($urandom_range(1) ? lim_x : -1);
      p.pos_y = rpp_pkg::POS_W'($urandom_range(lim_y - 1));
    end else begin
      p.pos_x = rpp_pkg::POS_W'($urandom);
      p.pos_y = rpp_pkg::POS_W'($urandom);
    end
    p.rgb_color = rpp_pkg::COLOR_W'($urandom);
    colour_class = $urandom_range(2);
    if (colour_class != 2) begin
      p.rgb_color[rpp_pkg::COLOR_R_BIT] = colour_class[0];
      p.rgb_color[rpp_pkg::COLOR_G_BIT] = colour_class[0];
      p.rgb_color[rpp_pkg::COLOR_B_BIT] = colour_class[0];
    end
    prev_x = $signed(p.pos_x);
    prev_y = $signed(p.pos_y);
    return p;
  endfunction

  // Offer one pixel, with optional idle cycles first, and log its expected byte
  task automatic send_pixel(rpp_pkg::pixel_in_t p, bit typed, rpp_pkg::pixel_out_t want);
    rpp_pkg::pixel_out_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= p;
    do @(posedge clk); while (!in_ready);
    predicted = plot_pixel(p);
    expected_writes.push_back(typed ? want : predicted);
  endtask

  // Register write once the pipeline has drained
  task automatic write_reg(logic [rpp_pkg::CFG_IDX_W-1:0] idx,
                           logic [rpp_pkg::CFG_DATA_W-1:0] val);
    in_valid <= 1'b0;
    while (expected_writes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      rpp_pkg::REG_ROTATION:       shadow_rotation = rpp_pkg::rotation_t'(val[1:0]);
      rpp_pkg::REG_RED_MAPS_WHITE: shadow_red_white = val[0];
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string field, int got, int want);
    $display("mismatch in %s at %0t ns: got 0x%0h, expected 0x%0h", field, $time, got, want);
    err_count++;
  endtask

  // Output side: random stalls plus the occasional long hold-off
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (rst) begin
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    rpp_pkg::pixel_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_writes.size() == 0) begin
        report_mismatch("unexpected result", out_data, 0);
      end else begin
        want = expected_writes.pop_front();
        if (want.plotted) plotted_count++;
        else dropped_count++;
        if (out_data.plotted !== want.plotted)
          report_mismatch("plotted", out_data.plotted, want.plotted);
        if (out_data.byte_address !== want.byte_address)
          report_mismatch("byte_address", out_data.byte_address, want.byte_address);
        if (out_data.byte_value !== want.byte_value)
          report_mismatch("byte_value", out_data.byte_value, want.byte_value);
      end
    end
  end

  // Stimulus
  initial begin
    int phase;
    foreach (shadow_frame[i]) shadow_frame[i] = 8'h00;
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;

    // Directed table, at reset settings first
    add_pixel(0, 0, 16'h0000, 1'b1, {1'b1, 13'd4735, 8'h00});
    add_pixel(0, 0, 16'hFFFF, 1'b1, {1'b1, 13'd4735, 8'h01});
    add_pixel(127, 295, 16'hFFFF, 1'b1, {1'b1, 13'd0, 8'h80});
    add_pixel(127, 295, 16'h8000, 1'b1, {1'b1, 13'd0, 8'h00});
    add_pixel(-1, 0, 16'hFFFF, 1'b1, DROPPED);
    add_pixel(0, -1, 16'hFFFF, 1'b1, DROPPED);
    add_pixel(128, 0, 16'hFFFF, 1'b1, DROPPED);
    add_pixel(0, 296, 16'hFFFF, 1'b1, DROPPED);
    add_pixel(-32768, -32768, 16'hFFFF, 1'b1, DROPPED);
    add_pixel(32767, 32767, 16'hFFFF, 1'b1, DROPPED);
    // same byte back to back exercises forwarding
    add_pixel(5, 7, 16'h0400, 1'b0, DROPPED);
    add_pixel(5, 6, 16'h0010, 1'b0, DROPPED);
    add_reg(rpp_pkg::REG_RED_MAPS_WHITE, rpp_pkg::CFG_DATA_W'(1));
    add_pixel(5, 5, 16'h8000, 1'b0, DROPPED);
    add_pixel(5, 5, 16'h7BEF, 1'b0, DROPPED);
    add_reg(rpp_pkg::REG_ROTATION, rpp_pkg::CFG_DATA_W'(rpp_pkg::ROT_90));
    add_pixel(295, 127, 16'hFFFF, 1'b0, DROPPED);
    add_pixel(296, 0, 16'hFFFF, 1'b1, DROPPED);
    add_pixel(0, 128, 16'hFFFF, 1'b1, DROPPED);
    add_reg(rpp_pkg::REG_ROTATION, rpp_pkg::CFG_DATA_W'(rpp_pkg::ROT_180));
    add_pixel(0, 0, 16'hFFFF, 1'b0, DROPPED);
    add_pixel(127, 295, 16'h0410, 1'b0, DROPPED);
    add_reg(rpp_pkg::REG_ROTATION, rpp_pkg::CFG_DATA_W'(rpp_pkg::ROT_270));
    add_pixel(295, 127, 16'hFFFF, 1'b0, DROPPED);
    add_pixel(0, 0, 16'h8410, 1'b0, DROPPED);
    add_reg(rpp_pkg::REG_ROTATION, rpp_pkg::CFG_DATA_W'(rpp_pkg::ROT_0));
    add_reg(rpp_pkg::REG_RED_MAPS_WHITE, rpp_pkg::CFG_DATA_W'(0));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // in_ready stays low through the post-reset clear; handshakes wait it out
    foreach (stim_table[k]) begin
      if (stim_table[k].kind == ROW_REG)
        write_reg(stim_table[k].idx, stim_table[k].val);
      else
        send_pixel(stim_table[k].pix, stim_table[k].typed, stim_table[k].want);
    end

    // Random phases: each rotation with both red mappings, four pacings
    for (phase = 0; phase < 8; phase++) begin
      write_reg(rpp_pkg::REG_ROTATION,
                rpp_pkg::CFG_DATA_W'(rpp_pkg::rotation_t'(phase / 2)));
      write_reg(rpp_pkg::REG_RED_MAPS_WHITE, rpp_pkg::CFG_DATA_W'(phase % 2));
      case (phase % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 62;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 62;
        end
        default: begin
          send_idle_pct = 32;
          recv_stall_pct = 32;
        end
      endcase
      // long output hold-off while pixels keep coming, to back up the pipeline
      if (phase % 4 == 0) hold_request = HOLD_OFF_CYCLES;
      repeat (ITEMS_PER_PHASE) send_pixel(random_pixel(), 1'b0, DROPPED);
    end

    in_valid <= 1'b0;
    while (expected_writes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d results: %0d plotted, %0d dropped, %0d mismatches.",
             plotted_count + dropped_count, plotted_count, dropped_count, err_count);
    $display("Covered all four rotations, both red mappings and four handshake pacings.");
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog, well beyond the clear pass plus the slowest paced traffic
  initial begin
    #1000000;
    $display("timeout with %0d results outstanding", expected_writes.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: files.f
hw/rtl/rpp_pkg.sv
hw/rtl/rpp_addr_gen.sv
hw/rtl/rpp_frame_mem.sv
hw/rtl/rpp_rmw.sv
hw/rtl/rotated_pixel_plot_1bpp_top.sv
verif/tb_rotated_pixel_plot_1bpp_top.sv
